@@ src/awr_pkg.sv @@
package awr_pkg;

  localparam int unsigned ADDR_W = 48;
  localparam int unsigned SIZE_W = 49;
  localparam int unsigned LIM_W  = 50;
  localparam int unsigned END_W  = 49;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned NUM_WIN = 4;

  localparam logic [SIZE_W-1:0] CHIP_APERTURE_SIZE_DEF = 49'd4294967296;

  localparam logic [2:0] TGT_CORE0    = 3'd0;
  localparam logic [2:0] TGT_CORE1    = 3'd1;
  localparam logic [2:0] TGT_CONTROL  = 3'd2;
  localparam logic [2:0] TGT_COUNTERS = 3'd3;
  localparam logic [2:0] TGT_OUTSIDE  = 3'd4;
  localparam logic [2:0] TGT_REFUSED  = 3'd5;

  localparam logic [1:0] CAUSE_NONE    = 2'd0;
  localparam logic [1:0] CAUSE_DECODE  = 2'd1;
  localparam logic [1:0] CAUSE_FOREIGN = 2'd2;
  localparam logic [1:0] CAUSE_SELF    = 2'd3;

  localparam logic [IDX_W-1:0] CFG_CHIP_BASE  = 4'd0;
  localparam logic [IDX_W-1:0] CFG_CORE0_BASE = 4'd1;
  localparam logic [IDX_W-1:0] CFG_CORE1_BASE = 4'd2;
  localparam logic [IDX_W-1:0] CFG_CORE_SIZE  = 4'd3;
  localparam logic [IDX_W-1:0] CFG_CTRL_BASE  = 4'd4;
  localparam logic [IDX_W-1:0] CFG_CTRL_SIZE  = 4'd5;
  localparam logic [IDX_W-1:0] CFG_CNT_BASE   = 4'd6;
  localparam logic [IDX_W-1:0] CFG_CNT_SIZE   = 4'd7;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [LIM_W-1:0]  lim;
    logic              nz;
  } win_t;

  typedef struct packed {
    logic [NUM_WIN-1:0] contain;
    logic [NUM_WIN-1:0] touch;
    logic               chip_touch;
    logic               len_zero;
    logic [1:0]         who;
  } hit_t;

endpackage

@@ src/address_window_router.sv @@
// Channel   | Direction | Handshake             | Payload
// request   | in        | start_i, busy_o       | requester_i, start_address_i, byte_count_i
// result    | out       | done_o (strobe)       | target_o, refusal_cause_o, core_bypass_o,
//           |           |                       | goes_outbound_o
// config    | in        | cfg_valid_i, cfg_ready_o | cfg_index_i, cfg_data_i
//
// One request per cycle; the result strobes once the request has passed the end-address, compare and route registers.
// Three register stages: end address, window compares, priority route.
// Window limits are registered in the cycle after the config register takes a write.
// rst_ni clears the pipeline valids and loads the register reset values.
// The result side has no back pressure, so busy_o stays low.
module address_window_router
  import awr_pkg::*;
#(
  parameter logic [SIZE_W-1:0] CHIP_APERTURE_SIZE = CHIP_APERTURE_SIZE_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [1:0]        requester_i,
  input  logic [ADDR_W-1:0] start_address_i,
  input  logic [LEN_W-1:0]  byte_count_i,
  output logic              done_o,
  output logic [2:0]        target_o,
  output logic [1:0]        refusal_cause_o,
  output logic              core_bypass_o,
  output logic              goes_outbound_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [IDX_W-1:0]  cfg_index_i,
  input  logic [SIZE_W-1:0] cfg_data_i
);

  win_t win   [NUM_WIN];
  win_t chip;
  logic hit_valid;
  hit_t hit;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  awr_cfg_regs #(
    .CHIP_APERTURE_SIZE(CHIP_APERTURE_SIZE)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i && cfg_ready_o),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .win_o     (win),
    .chip_o    (chip)
  );

  awr_range_cmp u_cmp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (start_i && !busy_o),
    .who_i       (requester_i),
    .addr_i      (start_address_i),
    .len_i       (byte_count_i),
    .win_i       (win),
    .chip_i      (chip),
    .hit_valid_o (hit_valid),
    .hit_o       (hit)
  );

  awr_route u_route (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hit_valid_i (hit_valid),
    .hit_i       (hit),
    .done_o      (done_o),
    .target_o    (target_o),
    .cause_o     (refusal_cause_o),
    .bypass_o    (core_bypass_o),
    .outbound_o  (goes_outbound_o)
  );

endmodule

@@ src/awr_cfg_regs.sv @@
module awr_cfg_regs
  import awr_pkg::*;
#(
  parameter logic [SIZE_W-1:0] CHIP_APERTURE_SIZE = CHIP_APERTURE_SIZE_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [IDX_W-1:0]  wr_idx_i,
  input  logic [SIZE_W-1:0] wr_data_i,
  output win_t              win_o [NUM_WIN],
  output win_t              chip_o
);

  logic [ADDR_W-1:0] aper_base_q, core0_base_q, core1_base_q, ctrl_base_q, cnt_base_q;
  logic [SIZE_W-1:0] core_size_q, ctrl_size_q, cnt_size_q;
  win_t              win_q [NUM_WIN];
  win_t              chip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aper_base_q  <= '0;
      core0_base_q <= '0;
      core1_base_q <= '0;
      core_size_q  <= SIZE_W'(1);
      ctrl_base_q  <= '0;
      ctrl_size_q  <= SIZE_W'(1);
      cnt_base_q   <= '0;
      cnt_size_q   <= SIZE_W'(1);
    end else if (wr_en_i) begin
      case (wr_idx_i)
        CFG_CHIP_BASE:  aper_base_q  <= wr_data_i[ADDR_W-1:0];
        CFG_CORE0_BASE: core0_base_q <= wr_data_i[ADDR_W-1:0];
        CFG_CORE1_BASE: core1_base_q <= wr_data_i[ADDR_W-1:0];
        CFG_CORE_SIZE:  core_size_q  <= wr_data_i;
        CFG_CTRL_BASE:  ctrl_base_q  <= wr_data_i[ADDR_W-1:0];
        CFG_CTRL_SIZE:  ctrl_size_q  <= wr_data_i;
        CFG_CNT_BASE:   cnt_base_q   <= wr_data_i[ADDR_W-1:0];
        CFG_CNT_SIZE:   cnt_size_q   <= wr_data_i;
        default: ;
      endcase
    end
  end

  // window limits are precomputed so the compare stage sees one add less
  always_ff @(posedge clk_i) begin
    win_q[0].base <= core0_base_q;
    win_q[0].lim  <= LIM_W'(core0_base_q) + LIM_W'(core_size_q);
    win_q[0].nz   <= |core_size_q;
    win_q[1].base <= core1_base_q;
    win_q[1].lim  <= LIM_W'(core1_base_q) + LIM_W'(core_size_q);
    win_q[1].nz   <= |core_size_q;
    win_q[2].base <= ctrl_base_q;
    win_q[2].lim  <= LIM_W'(ctrl_base_q) + LIM_W'(ctrl_size_q);
    win_q[2].nz   <= |ctrl_size_q;
    win_q[3].base <= cnt_base_q;
    win_q[3].lim  <= LIM_W'(cnt_base_q) + LIM_W'(cnt_size_q);
    win_q[3].nz   <= |cnt_size_q;
    chip_q.base   <= aper_base_q;
    chip_q.lim    <= LIM_W'(aper_base_q) + LIM_W'(CHIP_APERTURE_SIZE);
    chip_q.nz     <= |CHIP_APERTURE_SIZE;
  end

  assign win_o  = win_q;
  assign chip_o = chip_q;

endmodule

@@ src/awr_range_cmp.sv @@
module awr_range_cmp
  import awr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        who_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [LEN_W-1:0]  len_i,
  input  win_t              win_i [NUM_WIN],
  input  win_t              chip_i,
  output logic              hit_valid_o,
  output hit_t              hit_o
);

  logic              s1_valid_q;
  logic [1:0]        s1_who_q;
  logic [ADDR_W-1:0] s1_addr_q;
  logic [END_W-1:0]  s1_end_q;
  logic              s1_len_zero_q;
  logic              s2_valid_q;
  hit_t              s2_hit_q;
  hit_t              hit_d;
  logic [LIM_W-1:0]  addr_x, end_x;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_who_q      <= who_i;
    s1_addr_q     <= addr_i;
    s1_end_q      <= END_W'(addr_i) + END_W'(len_i);
    s1_len_zero_q <= ~|len_i;
    s2_hit_q      <= hit_d;
  end

  assign addr_x = LIM_W'(s1_addr_q);
  assign end_x  = LIM_W'(s1_end_q);

  always_comb begin
    hit_d          = '0;
    hit_d.who      = s1_who_q;
    hit_d.len_zero = s1_len_zero_q;
    for (int i = 0; i < NUM_WIN; i++) begin
      hit_d.contain[i] = win_i[i].nz && (s1_addr_q >= win_i[i].base)
                         && (end_x <= win_i[i].lim);
      hit_d.touch[i]   = win_i[i].nz && !s1_len_zero_q && (addr_x < win_i[i].lim)
                         && (LIM_W'(win_i[i].base) < end_x);
    end
    hit_d.chip_touch = chip_i.nz && !s1_len_zero_q && (addr_x < chip_i.lim)
                       && (LIM_W'(chip_i.base) < end_x);
  end

  assign hit_valid_o = s2_valid_q;
  assign hit_o       = s2_hit_q;

endmodule

@@ src/awr_route.sv @@
module awr_route
  import awr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       hit_valid_i,
  input  hit_t       hit_i,
  output logic       done_o,
  output logic [2:0] target_o,
  output logic [1:0] cause_o,
  output logic       bypass_o,
  output logic       outbound_o
);

  logic       done_q;
  logic [2:0] target_q, target_d, dest;
  logic [1:0] cause_q, cause_d;
  logic       bypass_q, bypass_d;
  logic       outbound_q;

  always_comb begin
    dest = TGT_OUTSIDE;
    if (hit_i.len_zero)             dest = TGT_REFUSED;
    else if (hit_i.contain[0])      dest = TGT_CORE0;
    else if (hit_i.touch[0])        dest = TGT_REFUSED;
    else if (hit_i.contain[1])      dest = TGT_CORE1;
    else if (hit_i.touch[1])        dest = TGT_REFUSED;
    else if (hit_i.contain[2])      dest = TGT_CONTROL;
    else if (hit_i.touch[2])        dest = TGT_REFUSED;
    else if (hit_i.contain[3])      dest = TGT_COUNTERS;
    else if (hit_i.touch[3])        dest = TGT_REFUSED;
    else if (hit_i.chip_touch)      dest = TGT_REFUSED;

    target_d = dest;
    cause_d  = CAUSE_NONE;
    bypass_d = 1'b0;
    if (dest == TGT_REFUSED) begin
      cause_d = CAUSE_DECODE;
    end else if (hit_i.who[1]) begin
      if (dest == TGT_OUTSIDE) begin
        target_d = TGT_REFUSED;
        cause_d  = CAUSE_FOREIGN;
      end
    end else if (dest == {2'b00, hit_i.who[0]}) begin
      target_d = TGT_REFUSED;
      cause_d  = CAUSE_SELF;
    end else if (dest == {2'b00, ~hit_i.who[0]}) begin
      bypass_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= hit_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit_valid_i) begin
      target_q   <= target_d;
      cause_q    <= cause_d;
      bypass_q   <= bypass_d;
      outbound_q <= (target_d == TGT_OUTSIDE);
    end
  end

  assign done_o     = done_q;
  assign target_o   = target_q;
  assign cause_o    = cause_q;
  assign bypass_o   = bypass_q;
  assign outbound_o = outbound_q;

endmodule

@@ src/awr_checker.sv @@
module awr_checker
  import awr_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       done_o,
  input logic [2:0] target_o,
  input logic [1:0] refusal_cause_o,
  input logic       core_bypass_o,
  input logic       goes_outbound_o
);

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##3 done_o)
    else $error("accepted beat gave no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 3))
    else $error("result without accepted beat");

  a_cause_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (refusal_cause_o != CAUSE_NONE)) |-> (target_o == TGT_REFUSED))
    else $error("refusal cause on routed beat");

  a_refused_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (target_o == TGT_REFUSED)) |-> (!core_bypass_o && !goes_outbound_o
                                               && (refusal_cause_o != CAUSE_NONE)))
    else $error("refused beat has flags");

  a_outbound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (goes_outbound_o == (target_o == TGT_OUTSIDE)))
    else $error("outbound flag mismatch");

endmodule

bind address_window_router awr_checker u_awr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .done_o          (done_o),
  .target_o        (target_o),
  .refusal_cause_o (refusal_cause_o),
  .core_bypass_o   (core_bypass_o),
  .goes_outbound_o (goes_outbound_o)
);

@@ verif/tb_address_window_router.sv @@
`timescale 1ns / 1ps

module tb_address_window_router;
  import awr_pkg::*;

  localparam int unsigned PIPE_LAT    = 3;
  localparam int unsigned RAND_ITEMS  = 800;
  localparam int unsigned CALM_ITEMS  = 100;
  localparam logic [63:0] APERTURE    = 64'(CHIP_APERTURE_SIZE_DEF);
  localparam logic [48:0] SIZE_FULL   = 49'h1_0000_0000_0000;
  localparam logic [47:0] ADDR_MAX    = 48'hFFFF_FFFF_FFFF;

  localparam logic [1:0] REQ_CORE0   = 2'd0;
  localparam logic [1:0] REQ_CORE1   = 2'd1;
  localparam logic [1:0] REQ_EXT     = 2'd2;
  localparam logic [1:0] REQ_EXT_ALT = 2'd3;

  typedef struct packed {
    logic [2:0] target;
    logic [1:0] cause;
    logic       bypass;
    logic       outbound;
  } route_t;

  typedef struct {
    int          ph;
    logic [1:0]  who;
    logic [47:0] addr;
    logic [15:0] len;
    bit          typed;
    route_t      exp;
  } req_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [1:0]        requester_i;
  logic [ADDR_W-1:0] start_address_i;
  logic [LEN_W-1:0]  byte_count_i;
  logic              done_o;
  logic [2:0]        target_o;
  logic [1:0]        refusal_cause_o;
  logic              core_bypass_o;
  logic              goes_outbound_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [IDX_W-1:0]  cfg_index_i;
  logic [SIZE_W-1:0] cfg_data_i;

  address_window_router uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .requester_i    (requester_i),
    .start_address_i(start_address_i),
    .byte_count_i   (byte_count_i),
    .done_o         (done_o),
    .target_o       (target_o),
    .refusal_cause_o(refusal_cause_o),
    .core_bypass_o  (core_bypass_o),
    .goes_outbound_o(goes_outbound_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // shadow of the window registers, windows in priority order
  logic [47:0] aper_base;
  logic [47:0] win_base [NUM_WIN];
  logic [48:0] win_size [NUM_WIN];

  route_t   route_q [$];
  req_row_t directed_rows [$];
  int n_sent, n_checked, n_cfg_writes, n_layouts, n_errors;

  function automatic route_t predict_route(logic [1:0] who, logic [47:0] addr,
                                           logic [15:0] len);
    logic [63:0] a, al, b, bl;
    logic [2:0]  dest;
    bit          found;
    route_t      r;
    a = 64'(addr);
    al = 64'(len);
    dest = TGT_OUTSIDE;
    found = (len == 16'd0);
    if (found) dest = TGT_REFUSED;
    for (int i = 0; i < NUM_WIN; i++) begin
      b = 64'(win_base[i]);
      bl = 64'(win_size[i]);
      if (!found && bl != 64'd0) begin
        if (a >= b && a + al <= b + bl) begin
          dest = 3'(i);
          found = 1'b1;
        end else if (a < b + bl && b < a + al) begin
          dest = TGT_REFUSED;
          found = 1'b1;
        end
      end
    end
    if (!found && a < 64'(aper_base) + APERTURE && 64'(aper_base) < a + al)
      dest = TGT_REFUSED;
    r = '{target: dest, cause: CAUSE_NONE, bypass: 1'b0, outbound: 1'b0};
    if (dest == TGT_REFUSED) begin
      r.cause = CAUSE_DECODE;
    end else if (who == REQ_EXT || who == REQ_EXT_ALT) begin
      if (dest == TGT_OUTSIDE) begin
        r.target = TGT_REFUSED;
        r.cause = CAUSE_FOREIGN;
      end
    end else if (dest == 3'(who)) begin
      r.target = TGT_REFUSED;
      r.cause = CAUSE_SELF;
    end else if (dest == 3'(who ^ 2'd1)) begin
      r.bypass = 1'b1;
    end
    r.outbound = (r.target == TGT_OUTSIDE);
    return r;
  endfunction

  function automatic void add_row(int ph, logic [1:0] who, logic [47:0] addr,
                                  logic [15:0] len, bit typed, logic [2:0] tgt,
                                  logic [1:0] cause, logic byp, logic outb);
    req_row_t row;
    row.ph = ph;
    row.who = who;
    row.addr = addr;
    row.len = len;
    row.typed = typed;
    row.exp = '{target: tgt, cause: cause, bypass: byp, outbound: outb};
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  function automatic logic [48:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return 49'd0;
      1:       return 49'd1;
      2:       return SIZE_FULL;
      3:       return 49'({$urandom, $urandom});
      4, 5:    return 49'd1 << $urandom_range(4, 32);
      default: return 49'($urandom_range(1, 32'h40000));
    endcase
  endfunction

  function automatic logic [48:0] pick_extreme_base();
    case ($urandom_range(0, 3))
      0:       return 49'd0;
      1:       return {1'b1, ADDR_MAX};
      2:       return 49'h0_FFFF_FFFF_F000;
      default: return 49'(ADDR_MAX - 48'($urandom_range(0, 32'hFFFF)));
    endcase
  endfunction

  function automatic logic [48:0] pick_extreme_size();
    case ($urandom_range(0, 3))
      0:       return 49'd0;
      1:       return 49'd1;
      2:       return SIZE_FULL;
      default: return '1;
    endcase
  endfunction

  always @(posedge clk_i) begin
    route_t exp;
    if (rst_ni && done_o) begin
      if (route_q.size() == 0) begin
        $error("result beat with no request pending: target %0d", target_o);
        n_errors++;
      end else begin
        exp = route_q.pop_front();
        n_checked++;
        if (target_o !== exp.target) begin
          $error("target: expected %0d, actual %0d", exp.target, target_o);
          n_errors++;
        end
        if (refusal_cause_o !== exp.cause) begin
          $error("refusal_cause: expected %0d, actual %0d", exp.cause, refusal_cause_o);
          n_errors++;
        end
        if (core_bypass_o !== exp.bypass) begin
          $error("core_bypass: expected %0d, actual %0d", exp.bypass, core_bypass_o);
          n_errors++;
        end
        if (goes_outbound_o !== exp.outbound) begin
          $error("goes_outbound: expected %0d, actual %0d", exp.outbound, goes_outbound_o);
          n_errors++;
        end
      end
    end
  end

  task automatic cfg_write(logic [IDX_W-1:0] idx, logic [48:0] data, int idle_pct);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    n_cfg_writes++;
    case (idx)
      CFG_CHIP_BASE:  aper_base = data[47:0];
      CFG_CORE0_BASE: win_base[0] = data[47:0];
      CFG_CORE1_BASE: win_base[1] = data[47:0];
      CFG_CORE_SIZE: begin
        win_size[0] = data;
        win_size[1] = data;
      end
      CFG_CTRL_BASE:  win_base[2] = data[47:0];
      CFG_CTRL_SIZE:  win_size[2] = data;
      CFG_CNT_BASE:   win_base[3] = data[47:0];
      CFG_CNT_SIZE:   win_size[3] = data;
      default: ;
    endcase
    if ($urandom_range(0, 99) < idle_pct) begin
      cfg_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  task automatic load_layout(logic [48:0] chip, logic [48:0] b0, logic [48:0] b1,
                             logic [48:0] csz, logic [48:0] ctl_b, logic [48:0] ctl_s,
                             logic [48:0] cnt_b, logic [48:0] cnt_s, bit junk,
                             int idle_pct);
    cfg_write(CFG_CHIP_BASE, chip, idle_pct);
    cfg_write(CFG_CORE0_BASE, b0, idle_pct);
    cfg_write(CFG_CORE1_BASE, b1, idle_pct);
    cfg_write(CFG_CORE_SIZE, csz, idle_pct);
    cfg_write(CFG_CTRL_BASE, ctl_b, idle_pct);
    cfg_write(CFG_CTRL_SIZE, ctl_s, idle_pct);
    cfg_write(CFG_CNT_BASE, cnt_b, idle_pct);
    cfg_write(CFG_CNT_SIZE, cnt_s, idle_pct);
    // unmapped index, must not disturb anything
    if (junk)
      cfg_write(CFG_CNT_SIZE + 4'd1 + 4'($urandom_range(0, 7)),
                49'({$urandom, $urandom}), idle_pct);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    repeat (PIPE_LAT) @(posedge clk_i);
    n_layouts++;
  endtask

  task automatic random_layout(int idle_pct);
    logic [47:0] chip;
    case ($urandom_range(0, 2))
      0: begin
        chip = 48'({$urandom, $urandom}) & ~48'hFFFF_FFFF;
        load_layout({1'($urandom), chip}, 49'(chip + 48'($urandom)),
                    49'(chip + 48'($urandom)), pick_size(), 49'(chip + 48'($urandom)),
                    pick_size(), 49'(chip + 48'($urandom)), pick_size(),
                    1'($urandom), idle_pct);
      end
      1: begin
        load_layout(49'({$urandom, $urandom}), 49'({$urandom, $urandom}),
                    49'({$urandom, $urandom}), pick_size(), 49'({$urandom, $urandom}),
                    pick_size(), 49'({$urandom, $urandom}), pick_size(),
                    1'($urandom), idle_pct);
      end
      default: begin
        load_layout(pick_extreme_base(), pick_extreme_base(), pick_extreme_base(),
                    pick_extreme_size(), pick_extreme_base(), pick_extreme_size(),
                    pick_extreme_base(), pick_extreme_size(), 1'($urandom), idle_pct);
      end
    endcase
  endtask

  task automatic directed_layout(int ph, int idle_pct);
    if (ph == 1) begin
      // tidy map in the second 4 GB, counters overlap the top of control
      load_layout(49'h1_0000_0000, 49'h1_0000_0000, 49'h1_0001_0000, 49'h1_0000,
                  49'h1_0002_0000, 49'h1000, 49'h1_0002_0800, 49'h1000, 1'b1, idle_pct);
    end else begin
      // empty core windows, control reaching past the top of the address space
      load_layout({1'b1, 48'hFFFF_0000_0000}, {1'b1, ADDR_MAX}, 49'd0, 49'd0,
                  49'h0_FFFF_FFFF_F000, SIZE_FULL, 49'd0, 49'd1, 1'b1, idle_pct);
    end
  endtask

  task automatic gen_request(output logic [1:0] who, output logic [47:0] addr,
                             output logic [15:0] len);
    logic [63:0] sz, slack, off, anchor;
    int          i, kind;
    i = $urandom_range(0, NUM_WIN - 1);
    sz = 64'(win_size[i]);
    kind = $urandom_range(0, 99);
    who = ($urandom_range(0, 9) == 0) ? REQ_EXT_ALT : 2'($urandom_range(0, 2));
    case ($urandom_range(0, 3))
      0:       len = 16'd1;
      1:       len = 16'($urandom_range(1, 64));
      2:       len = 16'($urandom_range(1, 16'hFFFF));
      default: len = 16'hFFFF;
    endcase
    if (kind < 60 && sz != 64'd0) begin
      if (64'(len) > sz) len = 16'(sz);
      slack = sz - 64'(len);
      off = 64'($urandom_range(0, 32'h20000));
      if (off > slack) off = slack;
      if ($urandom_range(0, 1)) off = slack - off;
      addr = 48'(64'(win_base[i]) + off);
    end else if (kind < 90) begin
      case ($urandom_range(0, 3))
        0:       anchor = 64'(win_base[i]);
        1:       anchor = 64'(win_base[i]) + sz;
        2:       anchor = 64'(aper_base);
        default: anchor = 64'(aper_base) + APERTURE;
      endcase
      addr = 48'(anchor + 64'($urandom_range(0, 32'h20000)) - 64'h10000);
      if ($urandom_range(0, 19) == 0) len = 16'd0;
    end else begin
      addr = 48'({$urandom, $urandom});
      len = 16'($urandom);
    end
  endtask

  task automatic issue(logic [1:0] who, logic [47:0] addr, logic [15:0] len,
                       bit typed, route_t typed_exp, int idle_pct);
    start_i <= 1'b1;
    requester_i <= who;
    start_address_i <= addr;
    byte_count_i <= len;
    do @(posedge clk_i); while (busy_o);
    route_q.insert(route_q.size(), typed ? typed_exp : predict_route(who, addr, len));
    n_sent++;
    if ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (route_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 2) @(posedge clk_i);
  endtask

  initial begin
    int          cur_ph, n_rand, n_chunk, idle_pct;
    logic [1:0]  who;
    logic [47:0] addr;
    logic [15:0] len;
    route_t      none;
    rst_ni = 1'b0;
    start_i = 1'b0;
    requester_i = '0;
    start_address_i = '0;
    byte_count_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    aper_base = '0;
    for (int i = 0; i < NUM_WIN; i++) begin
      win_base[i] = '0;
      win_size[i] = 49'd1;
    end
    none = '0;

    // reset map: every window is the single byte at 0, aperture is [0, 4G)
    add_row(0, REQ_CORE0, 48'd0, 16'd1, 1'b1, TGT_REFUSED, CAUSE_SELF, 1'b0, 1'b0);
    add_row(0, REQ_CORE1, 48'd0, 16'd1, 1'b1, TGT_CORE0, CAUSE_NONE, 1'b1, 1'b0);
    add_row(0, REQ_EXT, 48'd0, 16'd1, 1'b1, TGT_CORE0, CAUSE_NONE, 1'b0, 1'b0);
    add_row(0, REQ_CORE0, 48'd0, 16'd0, 1'b1, TGT_REFUSED, CAUSE_DECODE, 1'b0, 1'b0);
    add_row(0, REQ_CORE0, 48'd0, 16'd2, 1'b1, TGT_REFUSED, CAUSE_DECODE, 1'b0, 1'b0);
    add_row(0, REQ_CORE1, 48'd1, 16'hFFFF, 1'b1, TGT_REFUSED, CAUSE_DECODE, 1'b0, 1'b0);
    add_row(0, REQ_CORE0, 48'hFFFF_FFFF, 16'd2, 1'b1, TGT_REFUSED, CAUSE_DECODE,
            1'b0, 1'b0);
    add_row(0, REQ_CORE0, ADDR_MAX, 16'hFFFF, 1'b1, TGT_OUTSIDE, CAUSE_NONE, 1'b0, 1'b1);
    add_row(0, REQ_CORE1, 48'h1_0000_0000, 16'd1, 1'b1, TGT_OUTSIDE, CAUSE_NONE,
            1'b0, 1'b1);
    add_row(0, REQ_EXT, ADDR_MAX, 16'd1, 1'b1, TGT_REFUSED, CAUSE_FOREIGN, 1'b0, 1'b0);
    add_row(0, REQ_EXT_ALT, ADDR_MAX, 16'hFFFF, 1'b1, TGT_REFUSED, CAUSE_FOREIGN,
            1'b0, 1'b0);
    add_row(1, REQ_CORE0, 48'h1_0001_0000, 16'hFFFF, 1'b0, TGT_CORE0, CAUSE_NONE,
            1'b0, 1'b0);
    add_row(1, REQ_CORE1, 48'h1_0001_0000, 16'd1, 1'b0, TGT_CORE0, CAUSE_NONE,
            1'b0, 1'b0);
    add_row(1, REQ_EXT, 48'h1_0001_FFFF, 16'd1, 1'b0, TGT_CORE0, CAUSE_NONE,
            1'b0, 1'b0);
    add_row(1, REQ_CORE0, 48'h1_0000_FFFF, 16'd2, 1'b0, TGT_CORE0, CAUSE_NONE,
            1'b0, 1'b0);
    add_row(1, REQ_CORE1, 48'h1_0002_0000, 16'h1000, 1'b0, TGT_CORE0, CAUSE_NONE,
            1'b0, 1'b0);
    add_row(1, REQ_CORE0, 48'h1_0002_0F00, 16'h200, 1'b0, TGT_CORE0, CAUSE_NONE,
            1'b0, 1'b0);
    add_row(1, REQ_EXT, 48'h1_0002_1000, 16'h800, 1'b0, TGT_CORE0, CAUSE_NONE,
            1'b0, 1'b0);
    add_row(1, REQ_EXT_ALT, 48'h1_0002_1000, 16'd1, 1'b0, TGT_CORE0, CAUSE_NONE,
            1'b0, 1'b0);
    add_row(1, REQ_CORE0, 48'h1_0010_0000, 16'd16, 1'b0, TGT_CORE0, CAUSE_NONE,
            1'b0, 1'b0);
    add_row(1, REQ_CORE1, 48'hFFFF_FFF0, 16'h20, 1'b0, TGT_CORE0, CAUSE_NONE,
            1'b0, 1'b0);
    add_row(2, REQ_CORE0, ADDR_MAX, 16'hFFFF, 1'b0, TGT_CORE0, CAUSE_NONE, 1'b0, 1'b0);
    add_row(2, REQ_CORE1, 48'd0, 16'd1, 1'b0, TGT_CORE0, CAUSE_NONE, 1'b0, 1'b0);
    add_row(2, REQ_CORE0, 48'hFFFF_0000_0000, 16'h10, 1'b0, TGT_CORE0, CAUSE_NONE,
            1'b0, 1'b0);
    add_row(2, REQ_EXT, 48'h10, 16'hFFFF, 1'b0, TGT_CORE0, CAUSE_NONE, 1'b0, 1'b0);
    add_row(2, REQ_CORE1, 48'h1000, 16'd5, 1'b0, TGT_CORE0, CAUSE_NONE, 1'b0, 1'b0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cur_ph = 0;
    idle_pct = 25;
    foreach (directed_rows[k]) begin
      if (directed_rows[k].ph != cur_ph) begin
        drain();
        cur_ph = directed_rows[k].ph;
        directed_layout(cur_ph, idle_pct);
      end
      issue(directed_rows[k].who, directed_rows[k].addr, directed_rows[k].len,
            directed_rows[k].typed, directed_rows[k].exp, idle_pct);
    end

    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      drain();
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        default: idle_pct = 35;
      endcase
      if (n_rand >= RAND_ITEMS - CALM_ITEMS) idle_pct = 0;
      random_layout(idle_pct);
      n_chunk = $urandom_range(50, 100);
      for (int j = 0; j < n_chunk && n_rand < RAND_ITEMS; j++) begin
        if (n_rand >= RAND_ITEMS - CALM_ITEMS) idle_pct = 0;
        gen_request(who, addr, len);
        issue(who, addr, len, 1'b0, none, idle_pct);
        n_rand++;
      end
    end
    drain();

    if (route_q.size() != 0) begin
      $error("%0d results never arrived", route_q.size());
      n_errors++;
    end
    $display("Covered %0d requests (%0d directed) over %0d window maps, %0d register writes",
             n_sent, directed_rows.size(), n_layouts, n_cfg_writes);
    $display("Compared %0d result beats, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("address_window_router regression: pass");
    end else begin
      $display("address_window_router regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("address_window_router regression: fail");
    $finish;
  end

endmodule
